// ===== sv/rmv_pkg.sv =====
package rmv_pkg;

    localparam int SAMPLE_W = 24;
    localparam int COUNT_W  = 32;
    localparam int FRAC_W   = 16;
    localparam int MEAN_W   = SAMPLE_W + FRAC_W;
    localparam int DIFF_W   = MEAN_W + 1;
    localparam int ANOM_W   = DIFF_W - FRAC_W;
    localparam int PROD_W   = 2 * ANOM_W;
    localparam int M2_W     = 64;
    localparam int VAR_W    = 32;
    localparam int SD_W     = 24;
    localparam int SQ_IN_W  = 2 * SD_W;
    localparam int SQ_REM_W = SD_W + 3;
    localparam int DIV_CNT_W = $clog2(M2_W);
    localparam int SQ_CNT_W  = $clog2(SD_W);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [M2_W-1:0] t_m2;

endpackage

// ===== sv/rmv_front.sv =====
module rmv_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  rmv_pkg::t_sample  i_sample,
    input  logic              i_take,
    output logic              o_avail,
    output rmv_pkg::t_sample  o_sample
);
    import rmv_pkg::*;

    t_sample    r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    logic       wr_en;
    logic       rd_en;

    assign full     = (r_fill == 2'd2);
    assign o_avail  = (r_fill != 2'd0);
    assign o_sample = r_slot[r_rd_ptr];
    assign wr_en    = push && !full;
    assign rd_en    = i_take && o_avail;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[r_wr_ptr] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({wr_en, rd_en})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

// ===== sv/rmv_div.sv =====
module rmv_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  rmv_pkg::t_m2      i_dividend,
    input  rmv_pkg::t_count   i_divisor,
    output logic              o_done,
    output rmv_pkg::t_m2      o_quotient
);
    import rmv_pkg::*;

    logic [COUNT_W-1:0]   r_rem;
    logic [M2_W-1:0]      r_quo;
    logic [COUNT_W-1:0]   r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [COUNT_W:0]     shifted;
    logic [COUNT_W:0]     diff;
    logic                 fits;

    assign shifted    = {r_rem, r_quo[M2_W-1]};
    assign diff       = shifted - {1'b0, r_dvs};
    assign fits       = !diff[COUNT_W];
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
            r_quo <= {r_quo[M2_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(M2_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== sv/rmv_sqrt.sv =====
module rmv_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rmv_pkg::SQ_IN_W-1:0] i_value,
    output logic                       o_done,
    output logic [rmv_pkg::SD_W-1:0]   o_root
);
    import rmv_pkg::*;

    logic [SQ_IN_W-1:0]  r_val;
    logic [SQ_REM_W-1:0] r_rem;
    logic [SD_W-1:0]     r_root;
    logic [SQ_CNT_W-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [SQ_REM_W-1:0] rem_sh;
    logic [SQ_REM_W-1:0] trial;
    logic                fits;

    assign rem_sh = {r_rem[SQ_REM_W-3:0], r_val[SQ_IN_W-1:SQ_IN_W-2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign fits   = (rem_sh >= trial);
    assign o_done = r_done;
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[SQ_IN_W-3:0], 2'b00};
            r_rem  <= fits ? rem_sh - trial : rem_sh;
            r_root <= {r_root[SD_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SQ_CNT_W'(SD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== sv/rmv_back.sv =====
module rmv_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_avail,
    input  rmv_pkg::t_sample         i_sample,
    output logic                     o_take,
    output logic                     empty,
    input  logic                     pop,
    output logic [31:0]              o_count,
    output logic signed [23:0]       o_mean,
    output logic [31:0]              o_variance,
    output logic [23:0]              o_std_dev,
    output logic                     o_saturated
);
    import rmv_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_PREP = 8'b0000_0010,
        ST_DIV1 = 8'b0000_0100,
        ST_MUL  = 8'b0000_1000,
        ST_ACC  = 8'b0001_0000,
        ST_CHK  = 8'b0010_0000,
        ST_DIV2 = 8'b0100_0000,
        ST_SQRT = 8'b1000_0000
    } t_state;

    t_state                    r_state;
    t_count                    r_count;
    logic signed [MEAN_W-1:0]  r_mean;
    t_m2                       r_m2;
    logic                      r_sat;
    logic signed [MEAN_W-1:0]  r_xw;
    logic signed [DIFF_W-1:0]  r_a1;
    logic [PROD_W-1:0]         r_term;
    logic [VAR_W-1:0]          r_var;
    logic                      r_vsat;
    logic                      r_out_valid;
    logic [31:0]               r_out_count;
    logic [23:0]               r_out_mean;
    logic [31:0]               r_out_var;
    logic [23:0]               r_out_sd;
    logic                      r_out_sat;

    logic signed [DIFF_W-1:0]  a1;
    logic [DIFF_W-1:0]         a1_mag;
    logic signed [DIFF_W-1:0]  step;
    logic signed [DIFF_W-1:0]  mean_sum;
    logic signed [DIFF_W-1:0]  a2;
    logic signed [ANOM_W-1:0]  q1;
    logic signed [ANOM_W-1:0]  q2;
    logic [ANOM_W-1:0]         m1;
    logic [ANOM_W-1:0]         m2m;
    logic [M2_W:0]             acc;
    logic [M2_W-1:0]           var_wide;
    logic                      var_clip;
    logic                      div_start;
    t_m2                       div_dividend;
    t_count                    div_divisor;
    logic                      div_done;
    t_m2                       div_quo;
    logic                      sq_start;
    logic                      sq_done;
    logic [SD_W-1:0]           sq_root;
    logic                      out_write;
    logic                      take;

    assign take   = (r_state == ST_IDLE) && i_avail && !r_out_valid;
    assign o_take = take;

    assign a1       = DIFF_W'(r_xw) - DIFF_W'(r_mean);
    assign a1_mag   = a1[DIFF_W-1] ? DIFF_W'(-a1) : a1;
    assign step     = r_a1[DIFF_W-1] ? -$signed(div_quo[DIFF_W-1:0])
                                     : $signed(div_quo[DIFF_W-1:0]);
    assign mean_sum = DIFF_W'(r_mean) + step;

    assign a2  = DIFF_W'(r_xw) - DIFF_W'(r_mean);
    assign q1  = r_a1[DIFF_W-1:FRAC_W];
    assign q2  = a2[DIFF_W-1:FRAC_W];
    assign m1  = q1[ANOM_W-1] ? ANOM_W'(-q1) : q1;
    assign m2m = q2[ANOM_W-1] ? ANOM_W'(-q2) : q2;

    assign acc = {1'b0, r_m2} + (M2_W + 1)'(r_term);

    // drop the fraction bits gained by the Q32.32 sum, then clip
    assign var_wide = {{FRAC_W{1'b0}}, div_quo[M2_W-1:FRAC_W]};
    assign var_clip = |var_wide[M2_W-1:VAR_W];

    assign div_start    = (r_state == ST_PREP) ||
                          ((r_state == ST_CHK) && (r_count >= COUNT_W'(2)));
    assign div_dividend = (r_state == ST_PREP) ? M2_W'(a1_mag) : r_m2;
    assign div_divisor  = (r_state == ST_PREP) ? r_count : r_count - COUNT_W'(1);
    assign sq_start     = (r_state == ST_DIV2) && div_done;
    assign out_write    = ((r_state == ST_CHK) && (r_count < COUNT_W'(2))) ||
                          ((r_state == ST_SQRT) && sq_done);

    rmv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    rmv_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value ({(var_clip ? {VAR_W{1'b1}} : var_wide[VAR_W-1:0]), {FRAC_W{1'b0}}}),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_xw <= {i_sample, {FRAC_W{1'b0}}};
        end
        if (r_state == ST_PREP) begin
            r_a1 <= a1;
        end
        if (r_state == ST_MUL) begin
            r_term <= (q1[ANOM_W-1] != q2[ANOM_W-1]) ? '0 : m1 * m2m;
        end
        if (sq_start) begin
            r_var  <= var_clip ? {VAR_W{1'b1}} : var_wide[VAR_W-1:0];
            r_vsat <= var_clip;
        end
        if (out_write) begin
            r_out_count <= r_count[31:0];
            r_out_mean  <= r_mean[MEAN_W-1:FRAC_W];
            r_out_var   <= (r_state == ST_SQRT) ? r_var : '0;
            r_out_sd    <= (r_state == ST_SQRT) ? sq_root : '0;
            r_out_sat   <= r_sat || ((r_state == ST_SQRT) && r_vsat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_mean      <= '0;
            r_m2        <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_write) begin
                r_out_valid <= 1'b1;
            end else if (pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (take) begin
                        // hold the count at its maximum once it saturates
                        if (r_count == {COUNT_W{1'b1}}) begin
                            r_sat <= 1'b1;
                        end else begin
                            r_count <= r_count + COUNT_W'(1);
                        end
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: r_state <= ST_DIV1;
                ST_DIV1: begin
                    if (div_done) begin
                        r_mean  <= mean_sum[MEAN_W-1:0];
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL:  r_state <= ST_ACC;
                ST_ACC: begin
                    if (acc[M2_W]) begin
                        r_m2  <= {M2_W{1'b1}};
                        r_sat <= 1'b1;
                    end else begin
                        r_m2 <= acc[M2_W-1:0];
                    end
                    r_state <= ST_CHK;
                end
                ST_CHK: r_state <= (r_count >= COUNT_W'(2)) ? ST_DIV2 : ST_IDLE;
                ST_DIV2: begin
                    if (div_done) begin
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (sq_done) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign empty       = !r_out_valid;
    assign o_count     = r_out_count;
    assign o_mean      = r_out_mean;
    assign o_variance  = r_out_var;
    assign o_std_dev   = r_out_sd;
    assign o_saturated = r_out_sat;

endmodule

// ===== sv/running_mean_variance_core.sv =====
// Welford running mean and variance over signed Q8.16 samples. Each sample
// pushed yields one result: saturating count, mean (Q8.16), sample variance
// m2/(n-1) in Q16.16 and its square root in Q8.16; variance and std_dev read
// zero until two samples have arrived. A two-entry sample queue takes input
// while the arithmetic runs. In the back end a 64-step shared radix-2
// divider runs for the mean step and, from the second sample on, again
// for the variance, followed by a 24-step square root. One result is held
// at the output until popped.
module running_mean_variance_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  rmv_pkg::t_sample   i_sample,
    output logic               empty,
    input  logic               pop,
    output logic [31:0]        o_count,
    output logic signed [23:0] o_mean,
    output logic [31:0]        o_variance,
    output logic [23:0]        o_std_dev,
    output logic               o_saturated
);
    import rmv_pkg::*;

    logic    q_avail;
    logic    q_take;
    t_sample q_sample;

    rmv_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_sample (i_sample),
        .i_take   (q_take),
        .o_avail  (q_avail),
        .o_sample (q_sample)
    );

    rmv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_avail     (q_avail),
        .i_sample    (q_sample),
        .o_take      (q_take),
        .empty       (empty),
        .pop         (pop),
        .o_count     (o_count),
        .o_mean      (o_mean),
        .o_variance  (o_variance),
        .o_std_dev   (o_std_dev),
        .o_saturated (o_saturated)
    );

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rmv_pkg::*;

    localparam int N_RANDOM     = 400;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_START   = 4000;
    localparam int HOLD_CYCLES  = 800;
    localparam int DRAIN_CYCLES = 400;

    typedef struct packed {
        logic [31:0]        count;
        logic signed [23:0] mean;
        logic [31:0]        variance;
        logic [23:0]        std_dev;
        logic               saturated;
    } t_stats;

    typedef struct packed {
        t_sample sample;
        logic    typed;
        t_stats  stats;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    t_sample            i_sample;
    logic               empty;
    logic               pop;
    logic [31:0]        o_count;
    logic signed [23:0] o_mean;
    logic [31:0]        o_variance;
    logic [23:0]        o_std_dev;
    logic               o_saturated;

    running_mean_variance_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_sample    (i_sample),
        .empty       (empty),
        .pop         (pop),
        .o_count     (o_count),
        .o_mean      (o_mean),
        .o_variance  (o_variance),
        .o_std_dev   (o_std_dev),
        .o_saturated (o_saturated)
    );

    // predictor state
    t_count      pred_count;
    longint      pred_mean;
    logic [63:0] pred_m2;
    logic        pred_sat;

    t_stats      stats_q[$];
    int          n_errors;
    int          cycle_cnt;
    logic        no_idle;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = 0;
        for (int i = 25; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (t * t <= v) begin
                r = t;
            end
        end
        return r;
    endfunction

    // Welford update of the running stats for one sample
    function automatic t_stats welford_update(t_sample s);
        longint       xw;
        longint       a1;
        longint       a2;
        longint       q1;
        longint       q2;
        logic [63:0]  m1;
        logic [63:0]  m2m;
        logic [63:0]  term;
        logic [63:0]  quo;
        logic [63:0]  vr;
        logic [127:0] prod;
        logic [64:0]  sum;
        logic         vsat;
        t_stats       r;
        vsat = 1'b0;
        vr = 0;
        r.std_dev = 0;
        if (pred_count == '1) begin
            pred_sat = 1'b1;
        end else begin
            pred_count++;
        end
        xw = longint'(s) * 65536;
        a1 = xw - pred_mean;
        pred_mean = pred_mean + a1 / longint'({32'd0, pred_count});
        a2 = xw - pred_mean;
        q1 = a1 >>> 16;
        q2 = a2 >>> 16;
        m1 = q1 < 0 ? -q1 : q1;
        m2m = q2 < 0 ? -q2 : q2;
        prod = {64'd0, m1} * {64'd0, m2m};
        if (((q1 < 0) != (q2 < 0)) || m1 == 0 || m2m == 0) begin
            term = 0;
        end else if (prod[127:64] != 0) begin
            term = '1;
            pred_sat = 1'b1;
        end else begin
            term = prod[63:0];
        end
        sum = {1'b0, pred_m2} + {1'b0, term};
        if (sum[64]) begin
            pred_m2 = '1;
            pred_sat = 1'b1;
        end else begin
            pred_m2 = sum[63:0];
        end
        if (pred_count >= 2) begin
            quo = pred_m2 / ({32'd0, pred_count} - 64'd1);
            vr = quo >> 16;
            if (vr > 64'hFFFF_FFFF) begin
                vr = 64'hFFFF_FFFF;
                vsat = 1'b1;
            end
            r.std_dev = 24'(floor_sqrt(vr << 16));
        end
        r.count = pred_count;
        r.mean = 24'(pred_mean >>> 16);
        r.variance = 32'(vr);
        r.saturated = pred_sat | vsat;
        return r;
    endfunction

    // offer one item, hold it until taken
    task automatic send_sample(t_sample s, logic typed, t_stats typed_stats);
        t_stats p;
        while (!no_idle && $urandom_range(99) < 15) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (full);
        p = welford_update(s);
        stats_q.push_back(typed ? typed_stats : p);
    endtask

    function automatic t_sample random_sample();
        int mode;
        int center;
        mode = $urandom_range(99);
        center = $urandom_range(2000) - 1000;
        if (mode < 50) begin
            return t_sample'((center <<< 12) + int'($urandom_range(8191)) - 4096);
        end else if (mode < 70) begin
            return t_sample'($urandom);
        end else if (mode < 85) begin
            return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
        end
        return t_sample'(int'($urandom_range(64)) - 32);
    endfunction

    // result side: random pops, one long hold-off, check against oldest expectation
    int hold_left;
    always @(posedge i_clk) begin
        t_stats e;
        if (i_rst_n && pop && !empty) begin
            if (stats_q.size() == 0) begin
                $display("%0t: unexpected item count=%0d", $time, o_count);
                n_errors++;
            end else begin
                e = stats_q.pop_front();
                if (o_count !== e.count) begin
                    $display("%0t: count exp %0d got %0d", $time, e.count, o_count);
                    n_errors++;
                end
                if (o_mean !== e.mean) begin
                    $display("%0t: mean exp %0d got %0d", $time, e.mean, o_mean);
                    n_errors++;
                end
                if (o_variance !== e.variance) begin
                    $display("%0t: variance exp %0d got %0d", $time, e.variance, o_variance);
                    n_errors++;
                end
                if (o_std_dev !== e.std_dev) begin
                    $display("%0t: std_dev exp %0d got %0d", $time, e.std_dev, o_std_dev);
                    n_errors++;
                end
                if (o_saturated !== e.saturated) begin
                    $display("%0t: saturated exp %0b got %0b", $time,
                             e.saturated, o_saturated);
                    n_errors++;
                end
            end
        end
        if (cycle_cnt == HOLD_START) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
        if (!i_rst_n || hold_left > 0 || cycle_cnt == HOLD_START) begin
            pop <= 1'b0;
        end else begin
            pop <= no_idle || $urandom_range(99) >= 15;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_stim_row rows[$];
        t_stats    none;
        none = '0;
        cycle_cnt = 0;
        hold_left = 0;
        n_errors = 0;
        no_idle = 1'b0;
        pred_count = 0;
        pred_mean = 0;
        pred_m2 = 0;
        pred_sat = 1'b0;
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_sample = '0;

        // first item after reset: mean equals the sample, no spread yet
        rows.push_back('{24'sh7FFFFF, 1'b1, '{32'd1, 24'sh7FFFFF, 32'd0, 24'd0, 1'b0}});
        rows.push_back('{24'sh800000, 1'b0, none});
        rows.push_back('{24'sh7FFFFF, 1'b0, none});
        rows.push_back('{24'sh800000, 1'b0, none});
        rows.push_back('{24'sh000000, 1'b0, none});
        rows.push_back('{24'shFFFFFF, 1'b0, none});
        rows.push_back('{24'sh000001, 1'b0, none});
        rows.push_back('{24'sh555555, 1'b0, none});
        rows.push_back('{24'shAAAAAA, 1'b0, none});
        rows.push_back('{24'sh010000, 1'b0, none});
        rows.push_back('{24'shFF0000, 1'b0, none});
        rows.push_back('{24'sh7FFFFF, 1'b0, none});
        rows.push_back('{24'sh7FFFFF, 1'b0, none});
        rows.push_back('{24'sh800000, 1'b0, none});
        rows.push_back('{24'sh800000, 1'b0, none});
        rows.push_back('{24'sh000000, 1'b0, none});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            send_sample(rows[i].sample, rows[i].typed, rows[i].stats);
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 100) begin
                no_idle = 1'b1;
            end
            if (i == 200) begin
                no_idle = 1'b0;
            end
            if (i == 300) begin
                // drain completely before going on
                push <= 1'b0;
                while (stats_q.size() != 0) @(posedge i_clk);
            end
            send_sample(random_sample(), 1'b0, none);
        end
        push <= 1'b0;
        while (stats_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
sv/rmv_pkg.sv
sv/rmv_front.sv
sv/rmv_div.sv
sv/rmv_sqrt.sv
sv/rmv_back.sv
sv/running_mean_variance_core.sv
verif/tb_top.sv
